>>> hdl/tccw_pkg.sv
// Shared constants for the text console cell writer: word layouts, operation
// codes, control characters and default screen geometry.
// No dependencies.
package tccw_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  // Input word fields
  localparam int FUNC_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int ENTRY_W  = 16;
  localparam int COORD_W  = 7;
  localparam int RADDR_W  = 11;
  localparam int IN_TDATA_W = 48;

  // Result word fields
  localparam int RDATA_W  = 16;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int POS_W    = 11;
  localparam int OUT_TDATA_W = 40;

  localparam int COLOR_W = 8;
  localparam logic [COLOR_W-1:0] COLOR_RST = 8'h07;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUTC  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUTE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SETC  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SETR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd5;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

endpackage

>>> hdl/tccw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/text_console_cell_writer.sv
// Text console cell writer: cell store, cursor and scroll/clear sequencer.
// Depends on tccw_pkg and tccw_ram.
// Put char/entry, set column/row and unused codes respond without leaving idle;
//   the result is registered and shows the cycle after the input word is taken.
// Read cell: RAM read, capture, respond. Clear: a blanking pass over every cell, then respond.
// A put that scrolls moves the rows up, one cell per cycle through the single RAM
//   read/write port pair, then blanks the bottom row and responds.
// Reset: cursor homes, the blank color register loads 7, then a clearing pass writes
//   zero to all SCREEN_WIDTH*SCREEN_HEIGHT cells (2000 at default) with in_tready low.
module text_console_cell_writer #(
  parameter int SCREEN_WIDTH  = tccw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tccw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // func[2:0], char_code[10:3], cell_entry[26:11], coord[33:27], read_addr[44:34]
  input  logic [tccw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // read_data[15:0], cursor_col[22:16], cursor_row[27:23], cursor_pos[38:28]
  output logic [tccw_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tccw_pkg::COLOR_W-1:0]     cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  import tccw_pkg::*;

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam int SCR_N = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);

  // Sequencer states
  localparam logic [2:0] ST_FILL = 3'd0;  // write blank (or zero) over the store
  localparam logic [2:0] ST_IDLE = 3'd1;  // take a word
  localparam logic [2:0] ST_RDW  = 3'd2;  // capture RAM read data
  localparam logic [2:0] ST_SCRL = 3'd3;  // move rows up, one cell a cycle
  localparam logic [2:0] ST_RESP = 3'd4;  // hand the result to the output register

  // Input word fields
  logic [FUNC_W-1:0]  in_func;
  logic [CHAR_W-1:0]  in_char;
  logic [ENTRY_W-1:0] in_entry;
  logic [COORD_W-1:0] in_coord;
  logic [RADDR_W-1:0] in_raddr;

  assign in_func  = in_tdata[2:0];
  assign in_char  = in_tdata[10:3];
  assign in_entry = in_tdata[26:11];
  assign in_coord = in_tdata[33:27];
  assign in_raddr = in_tdata[44:34];

  // Registers
  logic [2:0]         state_r,    state_nxt;
  logic [AW-1:0]      idx_r,      idx_nxt;
  logic               init_r,     init_nxt;
  logic               pend_r,     pend_nxt;
  logic [AW-1:0]      wa_r,       wa_nxt;
  logic               rd_ok_r,    rd_ok_nxt;
  logic [RDATA_W-1:0] rd_data_r,  rd_data_nxt;
  logic [XW-1:0]      x_r,        x_nxt;
  logic [YW-1:0]      y_r,        y_nxt;
  logic [COLOR_W-1:0] color_r,    color_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RDATA_W-1:0] out_data_r, out_data_nxt;
  logic [XW-1:0]      out_x_r,    out_x_nxt;
  logic [YW-1:0]      out_y_r,    out_y_nxt;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  tccw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic               out_free;
  logic               in_acc;
  logic [ENTRY_W-1:0] blank;
  logic [ENTRY_W-1:0] put_entry;
  logic [CHAR_W-1:0]  put_char;
  logic [AW-1:0]      cur_addr;
  logic [AW-1:0]      out_pos;
  logic [7:0]         nx8;
  logic [6:0]         ny7;
  logic               put_wr;
  logic               put_scroll;
  logic               load_out;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign blank     = {color_r, CH_SPACE};
  assign put_entry = (in_func == FN_PUTC) ? {color_r, in_char} : in_entry;
  assign put_char  = put_entry[CHAR_W-1:0];

  // Linear position of the cursor: one multiply feeds the cell write address
  assign cur_addr = AW'(y_r) * AW'(SCREEN_WIDTH) + AW'(x_r);

  // Advance the cursor for a put: control characters move, others write and step; then wrap and flag a scroll
  always_comb begin
    nx8        = 8'(x_r);
    ny7        = 7'(y_r);
    put_wr     = 1'b0;
    put_scroll = 1'b0;
    if (put_char == CH_NL) begin
      nx8 = 8'd0;
      ny7 = ny7 + 7'd1;
    end else if (put_char == CH_CR) begin
      nx8 = 8'd0;
    end else if (put_char == CH_TAB) begin
      nx8 = (nx8 + 8'd4) & 8'hFC;
    end else begin
      put_wr = 1'b1;
      nx8    = nx8 + 8'd1;
    end
    if (nx8 >= 8'(SCREEN_WIDTH)) begin
      nx8 = 8'd0;
      ny7 = ny7 + 7'd1;
    end
    if (ny7 >= 7'(SCREEN_HEIGHT)) begin
      ny7        = 7'(SCREEN_HEIGHT - 1);
      put_scroll = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    init_nxt      = init_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    rd_ok_nxt     = rd_ok_r;
    rd_data_nxt   = rd_data_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = blank;
    ram_raddr     = AW'(in_raddr);

    // The user must write config only while idle; the block itself does not enforce this.
    if (cfg_valid) begin
      color_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rd_data_nxt = '0;
          unique case (in_func)
            FN_PUTC, FN_PUTE: begin
              ram_we    = put_wr;
              ram_waddr = cur_addr;
              ram_wdata = put_entry;
              x_nxt     = XW'(nx8);
              y_nxt     = YW'(ny7);
              if (put_scroll) begin
                state_nxt = ST_SCRL;
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
              end else begin
                load_out = 1'b1;
              end
            end
            FN_SETC: begin
              x_nxt = ({1'b0, in_coord} < 8'(SCREEN_WIDTH)) ? XW'(in_coord)
                                                            : XW'(SCREEN_WIDTH - 1);
              load_out = 1'b1;
            end
            FN_SETR: begin
              y_nxt = (in_coord < 7'(SCREEN_HEIGHT)) ? YW'(in_coord)
                                                     : YW'(SCREEN_HEIGHT - 1);
              load_out = 1'b1;
            end
            FN_CLEAR: begin
              x_nxt     = '0;
              y_nxt     = '0;
              idx_nxt   = '0;
              init_nxt  = 1'b0;
              state_nxt = ST_FILL;
            end
            FN_READ: begin
              rd_ok_nxt = (int'(in_raddr) < CELLS);
              state_nxt = ST_RDW;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_RDW: begin
        rd_data_nxt = rd_ok_r ? ram_rdata : '0;
        state_nxt   = ST_RESP;
      end
      ST_SCRL: begin
        // Write the cell fetched last cycle one row up
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (idx_r < AW'(SCR_N)) begin
          ram_raddr = idx_r + AW'(SCREEN_WIDTH);
          pend_nxt  = 1'b1;
          wa_nxt    = idx_r;
          idx_nxt   = idx_r + AW'(1);
        end else begin
          // Bottom row is left: blank it from here
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = init_r ? '0 : blank;
        if (idx_r == AW'(CELLS - 1)) begin
          state_nxt = init_r ? ST_IDLE : ST_RESP;
          init_nxt  = 1'b0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (state_r == ST_RESP) ? rd_data_r : '0;
      out_x_nxt     = x_nxt;
      out_y_nxt     = y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      idx_r       <= '0;
      init_r      <= 1'b1;
      pend_r      <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      color_r     <= COLOR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      init_r      <= init_nxt;
      pend_r      <= pend_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold without reset
  always_ff @(posedge clk) begin
    wa_r       <= wa_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rd_data_r  <= rd_data_nxt;
    out_data_r <= out_data_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  // Linear position of the reported cursor
  assign out_pos    = AW'(out_y_r) * AW'(SCREEN_WIDTH) + AW'(out_x_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, POS_W'(out_pos), ROW_W'(out_y_r), COL_W'(out_x_r), out_data_r};

  // Only the idle state takes words
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("in_tready outside idle");

  // Cursor stays on screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(x_r) < SCREEN_WIDTH)
    else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(y_r) < SCREEN_HEIGHT)
    else $error("cursor row off screen");

  // Clear starts the fill sweep at cell zero
  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_func == FN_CLEAR) |=> (state_r == ST_FILL && idx_r == '0))
    else $error("clear did not start fill");

  // Read capture always moves on to respond
  a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDW |=> state_r == ST_RESP)
    else $error("read capture stalled");

endmodule

>>> sim/tccw_console_checker.sv
// Checker for the text console cell writer: watches the input, result and
// color-write channels, predicts every cursor report and compares it.
// Depends on tccw_pkg.
module tccw_console_checker #(
  parameter int W = tccw_pkg::SCREEN_WIDTH_DEF,
  parameter int H = tccw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tccw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tccw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tccw_pkg::COLOR_W-1:0]     cfg_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  output int unsigned                      fault_count,
  output int unsigned                      pending_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int CELLS = W * H;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [RDATA_W-1:0] rdata;
  } cursor_report_t;

  logic [ENTRY_W-1:0] screen_cells [0:CELLS-1];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] fill_color;
  cursor_report_t     expected_reports [$];

  task automatic blank_cells(input int unsigned from, input int unsigned upto);
    for (int unsigned i = from; i < upto; i++)
      screen_cells[i] = {fill_color, CH_SPACE};
  endtask

  // Write a cell or act on a control character, then wrap and scroll.
  task automatic place_cell(input logic [ENTRY_W-1:0] entry_word);
    case (entry_word[CHAR_W-1:0])
      CH_NL: begin
        cur_row++;
        cur_col = 0;
      end
      CH_CR: cur_col = 0;
      CH_TAB: cur_col = (cur_col + 4) & ~32'd3;
      default: begin
        screen_cells[cur_row * W + cur_col] = entry_word;
        cur_col++;
      end
    endcase
    if (cur_col >= W) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= H) begin
      cur_row = H - 1;
      for (int unsigned i = 0; i < W * (H - 1); i++)
        screen_cells[i] = screen_cells[i + W];
      blank_cells(W * (H - 1), CELLS);
    end
  endtask

  task automatic apply_console_op(input logic [IN_TDATA_W-1:0] w,
                                  output cursor_report_t rep);
    logic [FUNC_W-1:0]  fn;
    logic [CHAR_W-1:0]  ch;
    logic [ENTRY_W-1:0] entry;
    int unsigned        crd;
    int unsigned        addr;
    logic [RDATA_W-1:0] rd;
    fn    = w[2:0];
    ch    = w[10:3];
    entry = w[26:11];
    crd   = 32'(w[33:27]);
    addr  = 32'(w[44:34]);
    rd    = '0;
    case (fn)
      FN_PUTC:  place_cell({fill_color, ch});
      FN_PUTE:  place_cell(entry);
      FN_SETC:  cur_col = (crd < W) ? crd : W - 1;
      FN_SETR:  cur_row = (crd < H) ? crd : H - 1;
      FN_CLEAR: begin
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      FN_READ:  if (addr < CELLS) rd = screen_cells[addr];
      default: ;
    endcase
    rep.rdata = rd;
    rep.col   = cur_col[COL_W-1:0];
    rep.row   = cur_row[ROW_W-1:0];
    rep.pos   = POS_W'(cur_row * W + cur_col);
  endtask

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    cursor_report_t fresh;
    if (!rst_n) begin
      for (int unsigned i = 0; i < CELLS; i++) screen_cells[i] = '0;
      cur_col    = 0;
      cur_row    = 0;
      fill_color = COLOR_RST;
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(cursor_report_t)-1:0];
        if (expected_reports.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result word with nothing expected: %h", $realtime, out_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (got != want) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch rdata %h/%h col %0d/%0d row %0d/%0d pos %0d/%0d (exp/got)",
                       $realtime, want.rdata, got.rdata, want.col, got.col,
                       want.row, got.row, want.pos, got.pos);
          end
        end
      end
      if (cfg_valid && cfg_ready) fill_color = cfg_data;
      if (in_tvalid && in_tready) begin
        apply_console_op(in_tdata, fresh);
        expected_reports.push_back(fresh);
      end
    end
    pending_reports = expected_reports.size();
  end

endmodule

>>> sim/tb_text_console_cell_writer.sv
// Testbench top for the text console cell writer: drives command words and
// color writes, throttles both channels and gives the verdict.
// Depends on tccw_pkg, text_console_cell_writer and tccw_console_checker.
module tb_text_console_cell_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  // Unused operation codes; the block must treat them as no-ops.
  localparam logic [FUNC_W-1:0] FN_NOP6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_NOP7 = 3'd7;

  localparam int W               = SCREEN_WIDTH_DEF;
  localparam int H               = SCREEN_HEIGHT_DEF;
  localparam int PHASE_WORDS     = 275;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest quiet stretch: reset clearing pass or a scroll, plus the receiver
  // hold-off; taken several times over.
  localparam int STALL_LIMIT     = 20000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [COLOR_W-1:0]     cfg_data = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;

  int unsigned fault_count;
  int unsigned pending_reports;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  text_console_cell_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  tccw_console_checker #(.W(W), .H(H)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_data        (cfg_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .fault_count     (fault_count),
    .pending_reports (pending_reports)
  );

  // Receiver: random stalls at the current rate; once per run, hold off for a
  // long stretch so the result path backs up and in_tready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: abort when no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_text_console_cell_writer NOT OK");
      $finish;
    end
  end

  // Offer one command word; idle first at the sender's rate, then hold the
  // word until the block takes it.
  task automatic send_op(input logic [FUNC_W-1:0]  fn,
                         input logic [CHAR_W-1:0]  ch,
                         input logic [ENTRY_W-1:0] entry,
                         input logic [COORD_W-1:0] crd,
                         input logic [RADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, addr, crd, entry, ch, fn};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Drop valid and wait until every expected report has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly random bytes, with control characters now and then.
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(9))
      0: return CH_TAB;
      1: return CH_NL;
      2: return CH_CR;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  // Half the time anywhere in the 7-bit range (saturating), else on screen.
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span);
    if ($urandom_range(1) != 0) return COORD_W'($urandom_range(127));
    return COORD_W'($urandom_range(span - 1));
  endfunction

  // Place the cursor, write a short run of cells, read some of them back.
  task automatic send_text_run();
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int unsigned        base;
    int unsigned        len;
    logic [CHAR_W-1:0]  ch;
    col  = pick_coord(W);
    row  = pick_coord(H);
    base = ((row < H) ? row : H - 1) * W + ((col < W) ? col : W - 1);
    len  = $urandom_range(1, 12);
    send_op(FN_SETC, $urandom, $urandom, col, $urandom);
    send_op(FN_SETR, $urandom, $urandom, row, $urandom);
    for (int unsigned i = 0; i < len; i++) begin
      ch = pick_char();
      if ($urandom_range(2) == 0)
        send_op(FN_PUTE, $urandom, {8'($urandom), ch}, $urandom, $urandom);
      else
        send_op(FN_PUTC, ch, $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(1, 3))
      send_op(FN_READ, $urandom, $urandom, $urandom,
              RADDR_W'((base + $urandom_range(len)) % 2048));
  endtask

  // One unstructured command: any operation, any field values.
  task automatic send_noise_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)
      send_op(FN_PUTC, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 50)
      send_op(FN_PUTE, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 60)
      send_op(FN_SETC, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 70)
      send_op(FN_SETR, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 74)
      send_op(FN_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 92)
      send_op(FN_READ, $urandom, $urandom, $urandom, $urandom);
    else
      send_op(($urandom_range(1) != 0) ? FN_NOP7 : FN_NOP6,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  // Drain, load a new default color, clear with it, then run random traffic.
  task automatic run_phase(input logic [COLOR_W-1:0] color,
                           input int unsigned send_pct,
                           input int unsigned recv_pct);
    int unsigned stop_at;
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = words_sent + PHASE_WORDS;
    send_op(FN_CLEAR, $urandom, $urandom, $urandom, $urandom);
    while (words_sent < stop_at) begin
      // Halfway through the phase without idling, stall the receiver while
      // words keep coming.
      if (send_pct == 0 && recv_pct == 0 && words_sent + PHASE_WORDS / 2 >= stop_at)
        hold_off_req = 1'b1;
      if ($urandom_range(99) < 70) send_text_run();
      else send_noise_op();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset color, field extremes, control codes, wrap, scroll,
    // saturation, out-of-range read, unused codes, clear.
    send_op(FN_PUTC, "A", '0, '0, '0);
    send_op(FN_PUTC, 8'hFF, '0, '0, '0);
    send_op(FN_PUTE, '0, 16'hFFFF, '0, '0);
    send_op(FN_PUTE, '0, 16'hA500, '0, '0);
    send_op(FN_PUTC, CH_TAB, '0, '0, '0);
    send_op(FN_PUTC, CH_CR, '0, '0, '0);
    send_op(FN_PUTC, CH_NL, '0, '0, '0);
    send_op(FN_PUTE, '0, {8'h3C, CH_NL}, '0, '0);
    send_op(FN_PUTE, '0, {8'h11, CH_TAB}, '0, '0);
    send_op(FN_SETC, '0, '0, 7'd127, '0);
    send_op(FN_PUTC, "Z", '0, '0, '0);
    send_op(FN_SETC, '0, '0, 7'd78, '0);
    send_op(FN_PUTC, CH_TAB, '0, '0, '0);
    send_op(FN_SETR, '0, '0, 7'd127, '0);
    send_op(FN_SETC, '0, '0, 7'd79, '0);
    send_op(FN_PUTC, "B", '0, '0, '0);
    send_op(FN_PUTC, CH_NL, '0, '0, '0);
    send_op(FN_READ, '0, '0, '0, 11'd1919);
    send_op(FN_READ, '0, '0, '0, 11'd1999);
    send_op(FN_READ, '0, '0, '0, 11'd2047);
    send_op(FN_READ, '0, '0, '0, 11'd0);
    send_op(FN_NOP6, '1, '1, '1, '1);
    send_op(FN_NOP7, '0, '0, '0, '0);
    send_op(FN_CLEAR, '0, '0, '0, '0);
    send_op(FN_READ, '0, '0, '0, 11'd1234);

    run_phase(8'hFF, 8, 51);
    run_phase(8'h00, 51, 8);
    // No idling here; the receiver stalls once for a long stretch midway.
    run_phase(COLOR_W'($urandom), 0, 0);

    wait_for_drain();
    if (fault_count == 0 && pending_reports == 0)
      $display("tb_text_console_cell_writer OK");
    else
      $display("tb_text_console_cell_writer NOT OK");
    $finish;
  end

endmodule
